// File: src/tse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine package
// Shared widths, function codes, controller states and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tse_pkg;

	localparam int TSE_DEPTH_DEFAULT = 1024;

	localparam int FUNC_W     = 3;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 10;
	localparam int CNT_W      = 11;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR  = 3'd0,
		FUNC_APPEND = 3'd1,
		FUNC_COUNT  = 3'd2,
		FUNC_LINEAR = 3'd3,
		FUNC_BINARY = 3'd4
	} tse_func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_LINEAR,
		ST_BPROBE,
		ST_BCMP,
		ST_FINISH
	} tse_state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic scan_start;
		logic count_mode;
		logic scan_run;
		logic bin_start;
		logic bin_issue;
		logic bin_cmp;
		logic load_out;
	} tse_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic bin_empty;
		logic bin_eq;
		logic out_free;
	} tse_sts_t;

endpackage

// File: src/tse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/tse_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine datapath
// Table memory, length counter, scan pipeline, binary probe bounds and the
// output register.
// ----------------------------------------------------------------------------
module tse_datapath #(
	parameter int TABLE_DEPTH = tse_pkg::TSE_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tse_pkg::VALUE_W-1:0]  value,
	input  tse_pkg::tse_cmd_t            cmd,
	output tse_pkg::tse_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tse_pkg::OUT_DATA_W-1:0] out_data
);

	import tse_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = LW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	logic [LW-1:0]         len_q;
	logic [LW-1:0]         idx_q;
	logic [AW-1:0]         idx_s1;
	logic                  vld_s1;
	logic [VALUE_W-1:0]    key_q;
	logic                  count_mode_q;
	logic [LW-1:0]         count_q;
	logic                  hit_q;
	logic [AW-1:0]         pos_q;
	logic signed [SW-1:0]  lo_q;
	logic signed [SW-1:0]  hi_q;
	logic signed [SW-1:0]  mid_q;
	logic signed [SW:0]    sum;
	logic signed [SW-1:0]  mid;
	logic                  full;
	logic                  scan_issue;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_W-1:0]    rd_data;
	logic                  match_s1;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [AW+POS_W-1:0]   pos_ext;
	logic [LW+CNT_W-1:0]   cnt_ext;
	logic [POS_W-1:0]      pos_out;
	logic [CNT_W-1:0]      cnt_out;

	assign full       = (len_q == DEPTH_L);
	assign scan_issue = cmd.scan_run && (idx_q != len_q);
	assign sum        = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
	assign mid        = sum[SW:1];
	assign rd_en      = scan_issue || cmd.bin_issue;
	assign rd_addr    = cmd.bin_issue ? mid[AW-1:0] : idx_q[AW-1:0];
	assign match_s1   = vld_s1 && (rd_data == key_q);

	tse_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.append && !full),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				len_q <= '0;
			end else if (cmd.append && !full) begin
				len_q <= len_q + 1'b1;
			end
			vld_s1 <= scan_issue && !cmd.scan_start;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		if (cmd.scan_start) begin
			idx_q        <= '0;
			count_q      <= '0;
			hit_q        <= 1'b0;
			pos_q        <= '0;
			key_q        <= value;
			count_mode_q <= cmd.count_mode;
		end else if (cmd.bin_start) begin
			lo_q         <= '0;
			hi_q         <= $signed({1'b0, len_q}) - SW'(1);
			hit_q        <= 1'b0;
			pos_q        <= '0;
			key_q        <= value;
			count_mode_q <= 1'b0;
		end else begin
			if (scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (match_s1) begin
				count_q <= count_q + 1'b1;
				if (!hit_q) begin
					hit_q <= 1'b1;
					pos_q <= idx_s1;
				end
			end
			if (cmd.bin_issue) begin
				mid_q <= mid;
			end
			if (cmd.bin_cmp) begin
				if (rd_data == key_q) begin
					hit_q <= 1'b1;
					pos_q <= mid_q[AW-1:0];
				end else if ($signed(rd_data) > $signed(key_q)) begin
					hi_q <= mid_q - SW'(1);
				end else begin
					lo_q <= mid_q + SW'(1);
				end
			end
		end
	end

	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign cnt_ext = {{CNT_W{1'b0}}, count_q};
	assign pos_out = count_mode_q ? '0 : pos_ext[POS_W-1:0];
	assign cnt_out = count_mode_q ? cnt_ext[CNT_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {(OUT_DATA_W - CNT_W - POS_W - 1)'(0), cnt_out, pos_out, hit_q};
		end
	end

	assign sts.scan_done = (idx_q == len_q) && !vld_s1;
	assign sts.hit       = hit_q;
	assign sts.bin_empty = (lo_q > hi_q);
	assign sts.bin_eq    = (rd_data == key_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: src/tse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine controller
// Decodes each input transaction and sequences scans and binary probes.
// ----------------------------------------------------------------------------
module tse_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tse_pkg::FUNC_W-1:0]  func,
	input  tse_pkg::tse_sts_t           sts,
	output tse_pkg::tse_cmd_t           cmd
);

	import tse_pkg::*;

	tse_state_t state_q;
	tse_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (func)
						FUNC_CLEAR:  cmd.clear = 1'b1;
						FUNC_APPEND: cmd.append = 1'b1;
						FUNC_COUNT: begin
							cmd.scan_start = 1'b1;
							cmd.count_mode = 1'b1;
							state_d        = ST_COUNT;
						end
						FUNC_LINEAR: begin
							cmd.scan_start = 1'b1;
							state_d        = ST_LINEAR;
						end
						FUNC_BINARY: begin
							cmd.bin_start = 1'b1;
							state_d       = ST_BPROBE;
						end
						default: ;
					endcase
				end
			end
			ST_COUNT: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_LINEAR: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done || sts.hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_BPROBE: begin
				if (sts.bin_empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.bin_issue = 1'b1;
					state_d       = ST_BCMP;
				end
			end
			ST_BCMP: begin
				cmd.bin_cmp = 1'b1;
				state_d     = sts.bin_eq ? ST_FINISH : ST_BPROBE;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: src/table_search_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine
// Table of signed 32-bit words with append/clear and count, linear search
// and binary search queries.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser = function code, tdata = value (append data or
// query key). Output channel m_axis: one transaction per query carrying
// found, position and match count; clear and append produce none.
// Count and linear search read one table word per cycle from the
// single-read-port table memory plus its registered read; linear search
// can stop early on a hit. Binary search works each halving probe as an
// address step, then a compare on the registered read.
// One transaction is worked at a time; s_axis_tready is high only while the
// controller waits for a new one. A finished result sits in the output
// register, so the next transaction is taken while m_axis is stalled; a
// following query holds in its last cycle until that register frees.
// Reset empties the table (length zero) and drops any pending result; no
// memory clearing pass is needed.
// ----------------------------------------------------------------------------
module table_search_engine_unit #(
	parameter int TABLE_DEPTH = tse_pkg::TSE_DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tse_pkg::VALUE_W-1:0]    s_axis_tdata,  // value
	input  logic [tse_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tse_pkg::OUT_DATA_W-1:0] m_axis_tdata   // found, position, match_count
);

	import tse_pkg::*;

	tse_cmd_t cmd;
	tse_sts_t sts;

	tse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.func     (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	tse_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_COUNT ||
		s_axis_tuser == FUNC_LINEAR || s_axis_tuser == FUNC_BINARY) |=> !s_axis_tready)
		else $error("input accepted while a query is in progress");

	a_miss_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[POS_W:1] == '0)
		else $error("position nonzero without a hit");

	a_count_excl_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[POS_W+CNT_W:POS_W+1] != '0 |->
		m_axis_tdata[0] && m_axis_tdata[POS_W:1] == '0)
		else $error("count result with inconsistent found or position");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table search engine testbench
// Streams clear, append and query transactions into the engine and checks
// every query result against an in-bench table model, or a typed directed
// row against its listed result. A short table of directed vectors covers
// the empty table, the signed extremes, reserved codes and unsorted
// contents. Randomized phases then build sorted and scattered tables of
// random content and probe them with hit, near-miss and random keys. Both
// stream sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;

	import tse_pkg::*;

	localparam int TABLE_DEPTH   = TSE_DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS  = 540;
	localparam int STEADY_ITEMS  = 60;
	localparam int IDLE_LIMIT    = 5000;
	localparam int DRAIN_CYCLES  = 40;

	localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

	localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

	typedef enum int {
		PH_SORTED,
		PH_SCATTER,
		PH_NOISE
	} phase_kind_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] match_count;
	} search_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
		logic               typed;
		search_result_t     res;
	} search_vector_t;

	localparam search_vector_t DIRECTED_ROWS [25] = '{
		'{FUNC_COUNT,  32'd5,         1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_LINEAR, 32'd5,         1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_BINARY, 32'd5,         1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_RSVD_5, 32'd0,         1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_RSVD_6, 32'hFFFF_FFFF, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_RSVD_7, 32'h1234_5678, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'h8000_0000, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'hFFFF_FFFF, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'h0000_0000, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_BINARY, 32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd3, 11'd0}},
		'{FUNC_LINEAR, 32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd3, 11'd0}},
		'{FUNC_COUNT,  32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd0, 11'd2}},
		'{FUNC_BINARY, 32'h8000_0000, 1'b1, '{1'b1, 10'd0, 11'd0}},
		'{FUNC_LINEAR, 32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd1, 11'd0}},
		'{FUNC_COUNT,  32'd12345,     1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_BINARY, 32'd1,         1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_APPEND, 32'd3,         1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_BINARY, 32'd3,         1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_LINEAR, 32'd3,         1'b1, '{1'b1, 10'd5, 11'd0}},
		'{FUNC_RSVD_7, 32'd3,         1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_CLEAR,  32'hDEAD_BEEF, 1'b0, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_COUNT,  32'd3,         1'b1, '{1'b0, 10'd0, 11'd0}},
		'{FUNC_LINEAR, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, 11'd0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_valid = 1'b0;
	logic [VALUE_W-1:0]    s_data = '0;
	logic [FUNC_W-1:0]     s_func = FUNC_CLEAR;
	logic                  s_ready;
	logic                  m_valid;
	logic                  m_ready = 1'b0;
	logic [OUT_DATA_W-1:0] m_data;

	logic signed [VALUE_W-1:0] shadow_words [TABLE_DEPTH];
	int                        shadow_len = 0;

	search_result_t pending_results [$];

	int  errors = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  steady = 1'b0;
	bit  sender_idles = 1'b0;
	bit  counting = 1'b0;
	int  random_items = 0;
	int  n_append = 0, n_dropped = 0, n_clear = 0, n_ignored = 0;
	int  n_count = 0, n_linear = 0, n_binary = 0, n_hits = 0;

	table_search_engine_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata(s_data),
		.s_axis_tuser(s_func),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata(m_data)
	);

	always #6 clk = ~clk;

	// table model: updates state, returns the result a query produces
	task automatic search_table(input logic [FUNC_W-1:0] func,
			input logic signed [VALUE_W-1:0] key, output bit yields,
			output search_result_t res);
		int cnt;
		int lo;
		int hi;
		int mid;
		yields = 1'b0;
		res = '0;
		case (func)
			FUNC_CLEAR: begin
				shadow_len = 0;
				n_clear++;
			end
			FUNC_APPEND: begin
				if (shadow_len < TABLE_DEPTH) begin
					shadow_words[shadow_len] = key;
					shadow_len++;
					n_append++;
				end else begin
					n_dropped++;
				end
			end
			FUNC_COUNT: begin
				cnt = 0;
				for (int i = 0; i < shadow_len; i++)
					if (shadow_words[i] == key)
						cnt++;
				res.found = (cnt != 0);
				res.match_count = cnt[CNT_W-1:0];
				yields = 1'b1;
				n_count++;
			end
			FUNC_LINEAR: begin
				for (int i = 0; i < shadow_len; i++) begin
					if (shadow_words[i] == key) begin
						res.found = 1'b1;
						res.position = i[POS_W-1:0];
						break;
					end
				end
				yields = 1'b1;
				n_linear++;
			end
			FUNC_BINARY: begin
				lo = 0;
				hi = shadow_len - 1;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (shadow_words[mid] > key) begin
						hi = mid - 1;
					end else if (shadow_words[mid] < key) begin
						lo = mid + 1;
					end else begin
						res.found = 1'b1;
						res.position = mid[POS_W-1:0];
						break;
					end
				end
				yields = 1'b1;
				n_binary++;
			end
			default: begin
				n_ignored++;
			end
		endcase
	endtask

	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
			input bit typed = 1'b0, input search_result_t typed_res = '0);
		bit             yields;
		search_result_t res;
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_func  <= func;
		s_data  <= value;
		do @(posedge clk); while (!s_ready);
		search_table(func, value, yields, res);
		if (yields)
			pending_results.push_back(typed ? typed_res : res);
		if (counting && func <= FUNC_BINARY)
			random_items++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_key();
		int r;
		logic [VALUE_W-1:0] entry;
		r = $urandom_range(0, 19);
		entry = (shadow_len > 0) ? shadow_words[$urandom_range(0, shadow_len - 1)] : '0;
		if (shadow_len > 0 && r < 10)
			return entry;
		if (shadow_len > 0 && r < 13)
			return r[0] ? entry + 1 : entry - 1;
		if (r < 17)
			return $urandom;
		case (r)
			17: return VALUE_MIN;
			18: return VALUE_MAX;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_query();
		logic [FUNC_W-1:0] f;
		f = FUNC_W'($urandom_range(FUNC_COUNT, FUNC_BINARY));
		return f;
	endfunction

	task automatic run_queries(input int n);
		for (int i = 0; i < n; i++)
			send_item(pick_query(), pick_key());
	endtask

	task automatic run_phase(input phase_kind_t kind);
		int                 n;
		int                 vals [$];
		logic [FUNC_W-1:0]  f;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
		case (kind)
			PH_SORTED, PH_SCATTER: begin
				if ($urandom_range(0, 4) != 0)
					send_item(FUNC_CLEAR, $urandom);
				for (int i = 0; i < n; i++) begin
					if (i > 0 && $urandom_range(0, 4) == 0)
						vals.push_back(vals[i-1]);
					else if (kind == PH_SCATTER || $urandom_range(0, 1) == 0)
						vals.push_back($urandom_range(0, 8) - 4);
					else
						vals.push_back(int'($urandom));
				end
				if (kind == PH_SORTED)
					vals.sort();
				foreach (vals[i])
					send_item(FUNC_APPEND, vals[i]);
				run_queries($urandom_range(3, 10));
			end
			default: begin
				for (int i = 0; i < 12; i++) begin
					f = FUNC_W'($urandom_range(0, 7));
					send_item(f, $urandom_range(0, 1) ? pick_key() : $urandom);
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		search_result_t got;
		search_result_t want;
		got = m_data[CNT_W+POS_W:0];
		if (arst_n && m_valid && m_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, actual found=%0d position=%0d match_count=%0d",
					$time, m_data[0], m_data[POS_W:1], m_data[CNT_W+POS_W:POS_W+1]);
				errors++;
			end else begin
				want = pending_results.pop_front();
				got.found = m_data[0];
				got.position = m_data[POS_W:1];
				got.match_count = m_data[CNT_W+POS_W:POS_W+1];
				if (got.found !== want.found) begin
					$display("%0t: found mismatch, expected %0d actual %0d",
						$time, want.found, got.found);
					errors++;
				end
				if (got.position !== want.position) begin
					$display("%0t: position mismatch, expected %0d actual %0d",
						$time, want.position, got.position);
					errors++;
				end
				if (got.match_count !== want.match_count) begin
					$display("%0t: match_count mismatch, expected %0d actual %0d",
						$time, want.match_count, got.match_count);
					errors++;
				end
				if (got.found === 1'b1)
					n_hits++;
			end
		end
		if (stall_left > 0) begin
			m_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			m_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		phase_kind_t kind;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idles = 1'b1;
		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].value,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

		counting = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			steady = (random_items >= RANDOM_ITEMS - STEADY_ITEMS);
			sender_idles = !steady && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
				0, 1, 2: kind = PH_SORTED;
				3, 4: kind = PH_SCATTER;
				default: kind = PH_NOISE;
			endcase
			run_phase(kind);
		end
		s_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors += pending_results.size();
		end
		$display("Table ops: %0d appends (%0d dropped when full), %0d clears, %0d reserved codes",
			n_append, n_dropped, n_clear, n_ignored);
		$display("Queries: %0d count, %0d linear, %0d binary; %0d reported a hit; %0d errors",
			n_count, n_linear, n_binary, n_hits, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
